/* sv/m4m_pkg.sv */
// shared constants and types for the 4x4 Q16.16 matrix multiply block
// no dependencies; used by m4m_mac_unit and matrix4_multiply_top
package m4m_pkg;

    // default matrix dimension
    localparam int DIM_DEFAULT = 4;

    // element format and row geometry on the ports
    localparam int ELEM_W = 32;
    localparam int NCOL   = 4;
    localparam int ROW_W  = NCOL * ELEM_W;
    localparam int IDX_W  = 2;

    // fixed-point product handling
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int FRAC_W   = 16;
    localparam int SHPROD_W = PROD_W - FRAC_W;

    // stream payload widths, padded to whole bytes
    localparam int IN_FIELDS_W  = IDX_W + 2 * ROW_W;
    localparam int OUT_FIELDS_W = IDX_W + ROW_W;
    localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    // saturation limits
    localparam logic [ELEM_W-1:0] SAT_MAX = {1'b0, {(ELEM_W-1){1'b1}}};
    localparam logic [ELEM_W-1:0] SAT_MIN = {1'b1, {(ELEM_W-1){1'b0}}};

    // controls from the sequencer to the multiply-accumulate unit
    typedef struct packed {
        logic clear;  // zero the column accumulators
        logic load;   // a b row and its a element are valid this cycle
    } mac_ctl_t;

endpackage

/* sv/matrix4_multiply_top.sv */
// top level of the Q16.16 matrix multiply: row memories, sequencer, output register
// depends on m4m_pkg, m4m_row_mem and m4m_mac_unit
//
// Usage: each s_ transfer carries a row index plus that row of A and of B. Rows are
// written to two row-wide memories; an index of DIM or above is dropped. The transfer
// for row DIM-1 writes its row and then starts the product R = A x B, after which
// DIM result rows leave on the m_ channel from row 0 up, the last with m_tlast set.
// m_tuser marks a row where at least one element was clipped to the 32-bit range.
// For each result row the sequencer reads the A row once, then one B row per cycle
// through the single B read port into four multipliers, then drains a two-stage
// multiply and accumulate pipeline. s_tready is high only while no product is
// being computed. A result waits in the output register while m_tready is low; the
// sequencer then holds and the next row is not overwritten, while new input rows
// are still taken once the computation has finished.
// Reset (aresetn low, synchronous) clears the sequencer and the output valid; the
// row memories are not cleared and every row must be written before its first use.
module matrix4_multiply_top #(
    parameter int DIM = m4m_pkg::DIM_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    // input row stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // row_index[1:0], a_elem0..a_elem3, b_elem0..b_elem3 (32 bits each), zero pad
    input  logic [m4m_pkg::IN_TDATA_W-1:0]     s_tdata,
    // result row stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // out_row[1:0], prod_col0..prod_col3 (32 bits each), zero pad
    output logic [m4m_pkg::OUT_TDATA_W-1:0]    m_tdata,
    // saturated
    output logic                               m_tuser,
    // last_row
    output logic                               m_tlast
);

    localparam int ADDR_W = $clog2(DIM);
    localparam int EW     = m4m_pkg::ELEM_W;
    localparam int RW     = m4m_pkg::ROW_W;
    localparam int IW     = m4m_pkg::IDX_W;

    // sequencer states
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RDA   = 2'd1;
    localparam logic [1:0] S_RDB   = 2'd2;
    localparam logic [1:0] S_DRAIN = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    logic [ADDR_W-1:0] k1_reg;
    logic              rd_v_reg;

    logic [IW-1:0]     s_row;
    logic [RW-1:0]     s_a_row;
    logic [RW-1:0]     s_b_row;
    logic [RW-1:0]     b_masked;
    logic              in_xfer;
    logic              row_ok;
    logic              row_last;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;

    logic [RW-1:0]     a_rd_data;
    logic [RW-1:0]     b_rd_data;
    logic [EW-1:0]     a_sel;

    m4m_pkg::mac_ctl_t mac_ctl;
    logic              mac_busy;
    logic [RW-1:0]     sum_row;
    logic              sum_clip;

    logic              out_free;
    logic              out_load;
    logic              m_tvalid_reg;
    logic [RW-1:0]     out_data_reg;
    logic [IW-1:0]     out_row_reg;
    logic              out_clip_reg;
    logic              out_last_reg;

    // unpack the input transfer
    assign s_row   = s_tdata[IW-1:0];
    assign s_a_row = s_tdata[IW +: RW];
    assign s_b_row = s_tdata[IW+RW +: RW];

    assign s_tready = (state_reg == S_IDLE);
    assign in_xfer  = s_tvalid && s_tready;
    assign row_ok   = int'(s_row) < DIM;
    assign row_last = int'(s_row) == DIM - 1;
    assign wr_en    = in_xfer && row_ok;
    assign wr_addr  = ADDR_W'(s_row);

    // b columns at or beyond DIM are held as zero so those result columns read zero
    always_comb begin
        for (int n = 0; n < m4m_pkg::NCOL; n++) begin
            b_masked[n*EW +: EW] = (n < DIM) ? s_b_row[n*EW +: EW] : '0;
        end
    end

    // rows of A
    m4m_row_mem #(
        .DEPTH (DIM),
        .WIDTH (RW)
    ) u_left_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (s_a_row),
        .rd_en   (state_reg == S_RDA),
        .rd_addr (i_reg),
        .rd_data (a_rd_data)
    );

    // rows of B
    m4m_row_mem #(
        .DEPTH (DIM),
        .WIDTH (RW)
    ) u_right_store (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (b_masked),
        .rd_en   (state_reg == S_RDB),
        .rd_addr (k_reg),
        .rd_data (b_rd_data)
    );

    // track the b read in flight and its row number
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_v_reg <= 1'b0;
        end else begin
            rd_v_reg <= (state_reg == S_RDB);
        end
    end

    always_ff @(posedge aclk) begin
        k1_reg <= k_reg;
    end

    // pick a[i][k] matching the b row that just came out
    always_comb begin
        a_sel = '0;
        for (int n = 0; n < m4m_pkg::NCOL; n++) begin
            if (int'(k1_reg) == n) begin
                a_sel = a_rd_data[n*EW +: EW];
            end
        end
    end

    assign mac_ctl.clear = (state_reg == S_RDA);
    assign mac_ctl.load  = rd_v_reg;

    m4m_mac_unit #(
        .DIM (DIM)
    ) u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .a_elem  ($signed(a_sel)),
        .b_row   (b_rd_data),
        .busy    (mac_busy),
        .sum_row (sum_row),
        .clip    (sum_clip)
    );

    // sequencer: one result row per pass over the b rows
    assign out_free = !m_tvalid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        i_next     = i_reg;
        k_next     = k_reg;
        out_load   = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_xfer && row_last) begin
                    state_next = S_RDA;
                    i_next     = '0;
                end
            end
            S_RDA: begin
                state_next = S_RDB;
                k_next     = '0;
            end
            S_RDB: begin
                k_next = k_reg + 1'b1;
                if (k_reg == ADDR_W'(DIM - 1)) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!rd_v_reg && !mac_busy && out_free) begin
                    out_load = 1'b1;
                    if (i_reg == ADDR_W'(DIM - 1)) begin
                        state_next = S_IDLE;
                        i_next     = '0;
                    end else begin
                        state_next = S_RDA;
                        i_next     = i_reg + 1'b1;
                    end
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            i_reg     <= '0;
            k_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
            k_reg     <= k_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (out_load) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_data_reg <= sum_row;
            out_row_reg  <= IW'(i_reg);
            out_clip_reg <= sum_clip;
            out_last_reg <= (i_reg == ADDR_W'(DIM - 1));
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m4m_pkg::OUT_TDATA_W'({out_data_reg, out_row_reg});
    assign m_tuser  = out_clip_reg;
    assign m_tlast  = out_last_reg;

    // the last row of a matrix always starts a product
    a_last_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && int'(s_row) == DIM - 1) |=> state_reg == S_RDA)
        else $error("last input row did not start the product");

    // a b read result only exists while rows are being read or drained
    a_rd_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_v_reg |-> (state_reg == S_RDB || state_reg == S_DRAIN))
        else $error("b row data valid outside of a product pass");

    // the row counter is back at zero whenever the block is idle
    a_idle_row_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_IDLE |-> i_reg == '0)
        else $error("result row counter not cleared at idle");

endmodule

/* sv/m4m_row_mem.sv */
// row-wide synchronous memory, one write and one read port, registered read data
// no dependencies
module m4m_row_mem #(
    parameter int DEPTH = 4,
    parameter int WIDTH = 128
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read port, data registered when rd_en is high
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* sv/m4m_mac_unit.sv */
// four-column multiply-accumulate lane set with Q16.16 scaling and saturation
// depends on m4m_pkg
module m4m_mac_unit #(
    parameter int DIM = m4m_pkg::DIM_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  m4m_pkg::mac_ctl_t                  ctl,
    input  logic signed [m4m_pkg::ELEM_W-1:0]  a_elem,
    input  logic [m4m_pkg::ROW_W-1:0]          b_row,
    output logic                               busy,
    output logic [m4m_pkg::ROW_W-1:0]          sum_row,
    output logic                               clip
);

    localparam int ACC_W = m4m_pkg::SHPROD_W + $clog2(DIM) + 1;
    localparam int EW    = m4m_pkg::ELEM_W;

    logic signed [m4m_pkg::PROD_W-1:0] prod_reg [m4m_pkg::NCOL];
    logic signed [ACC_W-1:0]           acc_reg  [m4m_pkg::NCOL];
    logic                              prod_v_reg;
    logic [m4m_pkg::NCOL-1:0]          col_clip;

    // product stage valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_v_reg <= 1'b0;
        end else begin
            prod_v_reg <= ctl.load;
        end
    end

    // one 32x32 multiplier per column
    always_ff @(posedge aclk) begin
        if (ctl.load) begin
            for (int j = 0; j < m4m_pkg::NCOL; j++) begin
                prod_reg[j] <= a_elem * $signed(b_row[j*EW +: EW]);
            end
        end
    end

    // accumulate floor(product / 2^16) per column
    always_ff @(posedge aclk) begin
        for (int j = 0; j < m4m_pkg::NCOL; j++) begin
            if (ctl.clear) begin
                acc_reg[j] <= '0;
            end else if (prod_v_reg) begin
                acc_reg[j] <= acc_reg[j] + ACC_W'(prod_reg[j] >>> m4m_pkg::FRAC_W);
            end
        end
    end

    // clip each column sum to the signed 32-bit range
    always_comb begin
        for (int j = 0; j < m4m_pkg::NCOL; j++) begin
            col_clip[j] = !((&acc_reg[j][ACC_W-1:EW-1]) || !(|acc_reg[j][ACC_W-1:EW-1]));
            if (!col_clip[j]) begin
                sum_row[j*EW +: EW] = acc_reg[j][EW-1:0];
            end else if (acc_reg[j][ACC_W-1]) begin
                sum_row[j*EW +: EW] = m4m_pkg::SAT_MIN;
            end else begin
                sum_row[j*EW +: EW] = m4m_pkg::SAT_MAX;
            end
        end
    end

    assign clip = |col_clip;
    assign busy = prod_v_reg;

endmodule
